// File: design/aip_pkg.sv
// aip_pkg: shared types and constants of the ASCII integer parser.
// Used by aip_ctrl, aip_dpath and the top level ascii_integer_parser.
package aip_pkg;

    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned BASE_W     = 6;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned EXP_W      = 11;
    localparam int unsigned MANT_W     = 52;
    localparam int unsigned OUT_W      = 2 * VALUE_W + OFFSET_W;

    // exponent field for a mantissa aligned at bit 52 before normalization
    localparam logic [EXP_W-1:0] EXP_START = EXP_W'(1023 + 52);

    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_OCT = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);

    typedef enum logic [0:0] {
        CFG_BASE_SELECT = 1'b0,
        CFG_SIGNED_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_WS1,
        ST_WS2,
        ST_PFX,
        ST_DIG,
        ST_DONE,
        ST_NORM
    } t_state;

    typedef struct packed {
        logic clr;
        logic take;
        logic set_neg;
        logic base_oct;
        logic base_dec;
        logic base_hex;
        logic acc;
        logic norm_init;
        logic norm_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_ws;
        logic sign_ok;
        logic is_minus;
        logic is_zero;
        logic is_x;
        logic digit_ok;
        logic base_auto;
        logic norm_done;
    } t_sts;

endpackage

// File: design/aip_ctrl.sv
// aip_ctrl: parse phase and normalization sequencer of the ASCII integer parser.
// Depends on aip_pkg; drives aip_dpath through t_cmd, reads t_sts.
module aip_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_start,
    input  logic          i_out_ready,
    input  aip_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output aip_pkg::t_cmd o_cmd
);

    aip_pkg::t_state r_state, n_state, w_phase;
    logic            r_out_valid, n_out_valid;
    logic            w_can_load;

    assign w_phase    = i_start ? aip_pkg::ST_WS1 : r_state;
    assign w_can_load = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        if (r_state == aip_pkg::ST_NORM) begin
            if (i_sts.norm_done && w_can_load) begin
                n_state = aip_pkg::ST_DONE;
            end
        end else if (i_in_fire) begin
            unique case (w_phase)
                aip_pkg::ST_WS1, aip_pkg::ST_WS2: begin
                    if (i_sts.is_ws) begin
                        n_state = w_phase;
                    end else if (w_phase == aip_pkg::ST_WS1 && i_sts.sign_ok) begin
                        n_state = aip_pkg::ST_WS2;
                    end else if (i_sts.base_auto && i_sts.is_zero) begin
                        n_state = aip_pkg::ST_PFX;
                    end else if (i_sts.digit_ok) begin
                        n_state = aip_pkg::ST_DIG;
                    end else begin
                        n_state = aip_pkg::ST_NORM;
                    end
                end
                aip_pkg::ST_PFX: begin
                    if (i_sts.is_x || i_sts.digit_ok) begin
                        n_state = aip_pkg::ST_DIG;
                    end else begin
                        n_state = aip_pkg::ST_NORM;
                    end
                end
                aip_pkg::ST_DIG: begin
                    if (!i_sts.digit_ok) begin
                        n_state = aip_pkg::ST_NORM;
                    end
                end
                aip_pkg::ST_DONE: begin
                    n_state = aip_pkg::ST_DONE;
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    // commands
    always_comb begin
        o_cmd = '0;
        if (r_state == aip_pkg::ST_NORM) begin
            o_cmd.norm_step = !i_sts.norm_done;
            o_cmd.out_load  = i_sts.norm_done && w_can_load;
        end else if (i_in_fire) begin
            o_cmd.clr = i_start;
            unique case (w_phase)
                aip_pkg::ST_WS1, aip_pkg::ST_WS2: begin
                    if (i_sts.is_ws) begin
                        o_cmd.take = 1'b1;
                    end else if (w_phase == aip_pkg::ST_WS1 && i_sts.sign_ok) begin
                        o_cmd.take    = 1'b1;
                        o_cmd.set_neg = i_sts.is_minus;
                    end else if (i_sts.base_auto && i_sts.is_zero) begin
                        o_cmd.take     = 1'b1;
                        o_cmd.base_oct = 1'b1;
                    end else begin
                        o_cmd.base_dec  = i_sts.base_auto;
                        o_cmd.acc       = i_sts.digit_ok;
                        o_cmd.take      = i_sts.digit_ok;
                        o_cmd.norm_init = !i_sts.digit_ok;
                    end
                end
                aip_pkg::ST_PFX: begin
                    if (i_sts.is_x) begin
                        o_cmd.take     = 1'b1;
                        o_cmd.base_hex = 1'b1;
                    end else begin
                        o_cmd.acc       = i_sts.digit_ok;
                        o_cmd.take      = i_sts.digit_ok;
                        o_cmd.norm_init = !i_sts.digit_ok;
                    end
                end
                aip_pkg::ST_DIG: begin
                    o_cmd.acc       = i_sts.digit_ok;
                    o_cmd.take      = i_sts.digit_ok;
                    o_cmd.norm_init = !i_sts.digit_ok;
                end
                aip_pkg::ST_DONE: begin
                    o_cmd.clr = i_start;
                end
                default: begin
                    o_cmd = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aip_pkg::ST_WS1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state != aip_pkg::ST_NORM);
    assign o_out_valid = r_out_valid;

endmodule

// File: design/aip_dpath.sv
// aip_dpath: config registers, character classes, accumulator and
// one-bit-per-cycle double normalizer. Depends on aip_pkg.
module aip_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  aip_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [aip_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [7:0]                        i_ch,
    input  aip_pkg::t_cmd                     i_cmd,
    output aip_pkg::t_sts                     o_sts,
    output logic [aip_pkg::OUT_W-1:0]         o_result
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam int unsigned VW = aip_pkg::VALUE_W;
    localparam int unsigned BW = aip_pkg::BASE_W;
    localparam int unsigned OW = aip_pkg::OFFSET_W;
    localparam int unsigned EW = aip_pkg::EXP_W;
    localparam int unsigned MW = aip_pkg::MANT_W;

    logic [BW-1:0] r_cfg_base;
    logic          r_cfg_signed;
    logic [VW-1:0] r_accum, n_accum;
    logic          r_neg, n_neg;
    logic [BW-1:0] r_base, n_base;
    logic [OW-1:0] r_cons, n_cons;

    logic [VW-1:0] r_int;
    logic          r_sign;
    logic [VW-1:0] r_mag;
    logic [EW-1:0] r_exp;
    logic [OW-1:0] r_off;

    logic [VW-1:0] r_o_int, r_o_dbl;
    logic [OW-1:0] r_o_off;

    logic [VW-1:0]    w_eff_accum;
    logic             w_eff_neg;
    logic [BW-1:0]    w_eff_base, w_tbase, w_clamp;
    logic [OW-1:0]    w_eff_cons;
    logic [BW-1:0]    w_digit;
    logic             w_is_digit;
    logic [VW+BW-1:0] w_prod;
    logic [VW-1:0]    w_val, w_mag;

    assign w_clamp     = (r_cfg_base > aip_pkg::BASE_MAX) ? aip_pkg::BASE_MAX : r_cfg_base;
    assign w_eff_accum = i_cmd.clr ? '0 : r_accum;
    assign w_eff_neg   = i_cmd.clr ? 1'b0 : r_neg;
    assign w_eff_base  = i_cmd.clr ? w_clamp : r_base;
    assign w_eff_cons  = i_cmd.clr ? '0 : r_cons;
    assign w_tbase     = (w_eff_base == aip_pkg::BASE_AUTO) ? aip_pkg::BASE_DEC : w_eff_base;

    always_comb begin
        w_is_digit = 1'b1;
        w_digit    = '0;
        if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            w_digit = BW'(i_ch - CH_ZERO);
        end else if (i_ch >= CH_LA && i_ch <= CH_LZ) begin
            w_digit = BW'(i_ch - CH_LA + 8'd10);
        end else if (i_ch >= CH_UA && i_ch <= CH_UZ) begin
            w_digit = BW'(i_ch - CH_UA + 8'd10);
        end else begin
            w_is_digit = 1'b0;
        end
    end

    assign o_sts.is_ws     = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_LF);
    assign o_sts.sign_ok   = r_cfg_signed && ((i_ch == CH_PLUS) || (i_ch == CH_MINUS));
    assign o_sts.is_minus  = (i_ch == CH_MINUS);
    assign o_sts.is_zero   = (i_ch == CH_ZERO);
    assign o_sts.is_x      = (i_ch == CH_LX) || (i_ch == CH_UX);
    assign o_sts.digit_ok  = w_is_digit && (w_digit < w_tbase);
    assign o_sts.base_auto = (w_eff_base == aip_pkg::BASE_AUTO);
    // done once zero or the leading one sits at the hidden bit
    assign o_sts.norm_done = (r_mag == '0) || (r_mag[VW-1:MW] == (VW-MW)'(1));

    assign w_prod = w_eff_accum * w_tbase;
    assign w_val  = w_eff_neg ? (~w_eff_accum + VW'(1)) : w_eff_accum;
    assign w_mag  = w_val[VW-1] ? (~w_val + VW'(1)) : w_val;

    always_comb begin
        n_accum = w_eff_accum;
        if (i_cmd.acc) begin
            n_accum = w_prod[VW-1:0] + VW'(w_digit);
        end
        n_neg  = i_cmd.set_neg ? 1'b1 : w_eff_neg;
        n_base = w_eff_base;
        if (i_cmd.base_oct) begin
            n_base = aip_pkg::BASE_OCT;
        end else if (i_cmd.base_dec) begin
            n_base = aip_pkg::BASE_DEC;
        end else if (i_cmd.base_hex) begin
            n_base = aip_pkg::BASE_HEX;
        end
        n_cons = w_eff_cons;
        if (i_cmd.take && (w_eff_cons != '1)) begin
            n_cons = w_eff_cons + OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base   <= aip_pkg::BASE_DEC;
            r_cfg_signed <= 1'b1;
            r_accum      <= '0;
            r_neg        <= 1'b0;
            r_base       <= aip_pkg::BASE_DEC;
            r_cons       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    aip_pkg::CFG_BASE_SELECT: r_cfg_base   <= i_cfg_data;
                    aip_pkg::CFG_SIGNED_MODE: r_cfg_signed <= i_cfg_data[0];
                    default:                  r_cfg_base   <= r_cfg_base;
                endcase
            end
            r_accum <= n_accum;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_cons  <= n_cons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_init) begin
            r_int  <= w_val;
            r_sign <= w_val[VW-1];
            r_mag  <= w_mag;
            r_exp  <= aip_pkg::EXP_START;
            r_off  <= w_eff_cons;
        end else if (i_cmd.norm_step) begin
            if (r_mag[VW-1:MW+1] != '0) begin
                // round-up halving; magnitude never exceeds 2^63 so no carry out
                r_mag <= (r_mag + VW'(1)) >> 1;
                r_exp <= r_exp + EW'(1);
            end else begin
                r_mag <= r_mag << 1;
                r_exp <= r_exp - EW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_o_int <= r_int;
            r_o_dbl <= (r_mag == '0) ? '0 : {r_sign, r_exp, r_mag[MW-1:0]};
            r_o_off <= r_off;
        end
    end

    assign o_result = {r_o_off, r_o_dbl, r_o_int};

endmodule

// File: design/ascii_integer_parser.sv
// ascii_integer_parser: one character per cycle while whitespace, sign, prefix or
// digits are consumed. The terminating character stalls the input while the
// normalizer shifts one bit per cycle, and longer while an older result word still
// waits on the sink; the result word is valid as input reopens.
// Reset (synchronous, active low): base_select = 10, signed_mode = 1, parser idle.
// Config port is always ready.
module ascii_integer_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [7:0] ch
    input  logic                           i_s_axis_tuser,  // [0] start_req
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [63:0] int_value, [127:64] double_bits, [143:128] end_offset
    output logic [aip_pkg::OUT_W-1:0]      o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_index,
    input  logic [aip_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    aip_pkg::t_cmd w_cmd;
    aip_pkg::t_sts w_sts;
    logic          w_in_fire;

    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_s_axis_tvalid && o_s_axis_tready;

    aip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_start     (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    aip_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (aip_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_ch        (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_result    (o_m_axis_tdata)
    );

endmodule

// File: design/aip_checker.sv
// aip_checker: port-level checks of ascii_integer_parser, bound to the top level.
// Depends on aip_pkg for the result word width.
module aip_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [aip_pkg::OUT_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    a_zero_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[63:0] == 64'd0) == (o_m_axis_tdata[127:64] == 64'd0)))
        else $error("double zero does not match integer zero");

    a_sign_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[127] == o_m_axis_tdata[63]))
        else $error("double sign does not match integer sign");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: tb/tb_ascii_integer_parser.sv
`timescale 1ns / 100ps
// tb_ascii_integer_parser: self-checking bench for the ASCII integer parser.
// Streams characters through a queue-fed driver and checks each parsed word against
// an in-bench parser model; depends on aip_pkg and ascii_integer_parser only.
module tb_ascii_integer_parser;

    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE     = 64;
    localparam int PHASE_LEN  = 160;

    typedef struct {
        logic [7:0] ch;
        logic       start;
    } t_char_word;

    typedef struct {
        logic [63:0] value;
        logic [63:0] dbl;
        logic [15:0] offset;
    } t_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [7:0]                     i_s_axis_tdata = '0;
    logic                           i_s_axis_tuser = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [aip_pkg::OUT_W-1:0]      o_m_axis_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [0:0]                     i_cfg_index = '0;
    logic [aip_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    ascii_integer_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    t_char_word char_q[$];
    t_result    pending[$];

    // parser model state
    aip_pkg::t_state ph;
    logic [63:0]     acc;
    logic            neg;
    logic [5:0]      abase;
    logic [15:0]     used;
    logic [5:0]      base_reg;
    logic            sign_reg;

    logic  calm = 1'b0;
    logic  start_pend = 1'b0;
    logic  s_fire = 1'b0;
    int    src_gap = 0;
    int    snk_gap = 0;
    int    idle_cnt = 0;
    int    errors = 0;
    int    n_chars = 0;
    int    n_results = 0;
    int    n_cfg = 0;
    t_result    want;
    t_result    got;
    t_char_word nxt;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int digit_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "z") return int'(c - "a") + 10;
        if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [63:0] double_of(input logic [63:0] v);
        logic [63:0] m;
        logic        sg;
        int          e;
        sg = v[63];
        m  = sg ? -v : v;
        e  = 0;
        if (m == 64'd0) return 64'd0;
        while (m >= 64'h0020_0000_0000_0000) begin
            m = (m + 64'd1) >> 1;
            e++;
        end
        while (m < 64'h0010_0000_0000_0000) begin
            m = m << 1;
            e--;
        end
        return {sg, 11'(e + 52 + 1023), m[51:0]};
    endfunction

    function automatic void take_char();
        if (used != 16'hFFFF) used++;
    endfunction

    // advances the parser model by one character; returns 1 when a number ends
    function automatic bit parse_char(input logic [7:0] c, input logic st,
                                      output t_result r);
        int          d;
        logic [63:0] v;
        if (st) begin
            ph    = aip_pkg::ST_WS1;
            acc   = '0;
            neg   = 1'b0;
            abase = (base_reg > aip_pkg::BASE_MAX) ? aip_pkg::BASE_MAX : base_reg;
            used  = '0;
        end
        if (ph == aip_pkg::ST_DONE) return 1'b0;
        if (ph == aip_pkg::ST_WS1 || ph == aip_pkg::ST_WS2) begin
            if (c == " " || c == "\t" || c == "\n") begin
                take_char();
                return 1'b0;
            end
            if (ph == aip_pkg::ST_WS1 && sign_reg && (c == "-" || c == "+")) begin
                if (c == "-") neg = 1'b1;
                take_char();
                ph = aip_pkg::ST_WS2;
                return 1'b0;
            end
            if (abase == aip_pkg::BASE_AUTO) begin
                if (c == "0") begin
                    abase = aip_pkg::BASE_OCT;
                    take_char();
                    ph = aip_pkg::ST_PFX;
                    return 1'b0;
                end
                abase = aip_pkg::BASE_DEC;
            end
            ph = aip_pkg::ST_DIG;
        end else if (ph == aip_pkg::ST_PFX) begin
            ph = aip_pkg::ST_DIG;
            if (c == "x" || c == "X") begin
                abase = aip_pkg::BASE_HEX;
                take_char();
                return 1'b0;
            end
        end
        d = digit_val(c);
        if (d >= 0 && d < int'(abase)) begin
            acc = acc * 64'(abase) + 64'(d);
            take_char();
            return 1'b0;
        end
        v        = neg ? -acc : acc;
        r.value  = v;
        r.dbl    = double_of(v);
        r.offset = used;
        ph       = aip_pkg::ST_DONE;
        return 1'b1;
    endfunction

    // monitor: predicts on accepted characters and checks result words
    always @(posedge i_clk) begin
        s_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            ph       = aip_pkg::ST_WS1;
            acc      = '0;
            neg      = 1'b0;
            abase    = aip_pkg::BASE_DEC;
            used     = '0;
            base_reg = aip_pkg::BASE_DEC;
            sign_reg = 1'b1;
            idle_cnt = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (aip_pkg::t_cfg_idx'(i_cfg_index))
                    aip_pkg::CFG_BASE_SELECT: base_reg = i_cfg_data;
                    aip_pkg::CFG_SIGNED_MODE: sign_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (s_fire && parse_char(i_s_axis_tdata, i_s_axis_tuser, want))
                pending.push_back(want);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results++;
                got.value  = o_m_axis_tdata[63:0];
                got.dbl    = o_m_axis_tdata[127:64];
                got.offset = o_m_axis_tdata[143:128];
                if (pending.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    want = pending.pop_front();
                    if (got.value != want.value) begin
                        $display("%0t: int_value expected %h actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                    if (got.dbl != want.dbl) begin
                        $display("%0t: double_bits expected %h actual %h",
                                 $time, want.dbl, got.dbl);
                        errors++;
                    end
                    if (got.offset != want.offset) begin
                        $display("%0t: end_offset expected %0d actual %0d",
                                 $time, want.offset, got.offset);
                        errors++;
                    end
                end
            end
            if (s_fire || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // driver: source and sink, both with random idle bursts
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || s_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 3) - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (char_q.size() != 0) begin
                nxt = char_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= nxt.ch;
                i_s_axis_tuser  <= nxt.start;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            snk_gap = $urandom_range(1, 3) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic put(input logic [7:0] c);
        char_q.push_back('{ch: c, start: start_pend});
        start_pend = 1'b0;
        n_chars++;
    endtask

    task automatic add_text(input string s, input logic st);
        start_pend = st;
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 2))
            0:       return " ";
            1:       return "\t";
            default: return "\n";
        endcase
    endfunction

    task automatic add_number(input logic [5:0] base_cfg, input logic sgn);
        int eff;
        int n;
        start_pend = 1'b1;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                start_pend = $urandom_range(0, 1);
                put(8'($urandom_range(0, 255)));
            end
            start_pend = 1'b0;
            return;
        end
        eff = (base_cfg > aip_pkg::BASE_MAX) ? 36 : int'(base_cfg);
        repeat ($urandom_range(0, 3)) put(ws_char());
        if ((sgn && $urandom_range(0, 1)) || $urandom_range(0, 9) == 0) begin
            put($urandom_range(0, 1) ? "-" : "+");
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) put(ws_char());
            if ($urandom_range(0, 9) == 0) put($urandom_range(0, 1) ? "-" : "+");
        end
        if (eff == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    put("0");
                    eff = 8;
                end
                1: begin
                    put("0");
                    put($urandom_range(0, 1) ? "x" : "X");
                    eff = 16;
                end
                default: eff = 10;
            endcase
        end
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
        repeat (n) put(digit_char($urandom_range(0, eff - 1)));
        case ($urandom_range(0, 3))
            0:       put(8'h00);
            1:       put(ws_char());
            2:       put(eff < 36 ? digit_char(eff) : 8'("."));
            default: put(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (char_q.size() != 0 || i_s_axis_tvalid || pending.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input aip_pkg::t_cfg_idx idx,
                             input logic [aip_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic set_config(input logic [5:0] base, input logic sgn);
        cfg_write(aip_pkg::CFG_BASE_SELECT, base);
        cfg_write(aip_pkg::CFG_SIGNED_MODE, aip_pkg::CFG_DATA_W'(sgn));
    endtask

    initial begin
        logic [5:0] bases[10];
        logic [5:0] b;
        logic       sg;
        int         target;
        bases = '{6'd10, 6'd0, 6'd16, 6'd36, 6'd1, 6'd63, 6'd2, 6'd8, 6'd0, 6'd10};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: whitespace, sign, second sign, 0xFF end, ignored tail
        add_text(" \t\n-42", 1'b1);
        put(8'h00);
        add_text("+ -5", 1'b1);
        add_text("9", 1'b1);
        put(8'hFF);
        add_text("7", 1'b0);
        // config written mid number: sign seen live, base waits for next start
        add_text("  ", 1'b1);
        wait_idle();
        set_config(6'd16, 1'b0);
        add_text("-", 1'b0);
        add_text("aB", 1'b1);
        put(8'h00);
        wait_idle();
        set_config(aip_pkg::BASE_AUTO, 1'b0);
        add_text("0x1F ", 1'b1);
        add_text("0Xg", 1'b1);
        add_text("0178", 1'b1);
        add_text("-5", 1'b1);
        wait_idle();
        set_config(6'd63, 1'b1);
        add_text("zZ9.", 1'b1);
        wait_idle();
        set_config(6'd1, 1'b1);
        add_text("0010", 1'b1);

        for (int p = 0; p < 10; p++) begin
            wait_idle();
            b  = (p == 8) ? 6'($urandom_range(0, 63)) : bases[p];
            sg = (p == 8) ? 1'($urandom_range(0, 1)) : 1'(p % 2 == 0);
            calm = (p == 9);
            set_config(b, sg);
            target = n_chars + PHASE_LEN;
            while (n_chars < target) add_number(b, sg);
        end
        wait_idle();

        $display("Sent %0d characters, checked %0d parsed numbers, %0d register writes;",
                 n_chars, n_results, n_cfg);
        $display("bases auto, 1, 2, 8, 10, 16, 36 and above, signed and unsigned modes.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
